### design/sfsp_pkg.sv
package sfsp_pkg;

   localparam int CFG_W = 17;
   localparam int ARG_W = 14;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_MAGIC    = 3'd1,
      PH_TIMEOUT  = 3'd2,
      PH_COUNT    = 3'd3,
      PH_ARGLEN   = 3'd4,
      PH_ARGBYTES = 3'd5,
      PH_SKIP     = 3'd6,
      PH_HALT     = 3'd7
   } phase_type;

   localparam logic [2:0] KIND_TIMEOUT   = 3'd0;
   localparam logic [2:0] KIND_ARG_COUNT = 3'd1;
   localparam logic [2:0] KIND_ARG_LEN   = 3'd2;
   localparam logic [2:0] KIND_ARG_BYTE  = 3'd3;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd4;
   localparam logic [2:0] KIND_REJECTED  = 3'd5;

   localparam logic [2:0] ERR_OVERSIZE      = 3'd0;
   localparam logic [2:0] ERR_NOT_SUBMIT    = 3'd1;
   localparam logic [2:0] ERR_SHORT_HEADER  = 3'd2;
   localparam logic [2:0] ERR_COUNT_TOO_BIG = 3'd3;
   localparam logic [2:0] ERR_ARG_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_TRAILING      = 3'd5;
   localparam logic [2:0] ERR_SHORT_LENGTH  = 3'd6;

   localparam logic [2:0] MAGIC_LEN = 3'd6;

   typedef struct packed {
      logic [2:0]       result_kind;
      logic [31:0]      value;
      logic [ARG_W-1:0] arg_index;
      logic [2:0]       error_code;
      logic             frame_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } rsp_push_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h53;
         3'd1: b = 8'h55;
         3'd2: b = 8'h42;
         3'd3: b = 8'h4D;
         3'd4: b = 8'h49;
         3'd5: b = 8'h54;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### design/sfsp_core.sv
module sfsp_core
   import sfsp_pkg::*;
#(
   parameter int MAX_FRAME_LIMIT = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  logic [7:0]       data_byte,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_max_frame_size,
   output rsp_push_type     push
);

   localparam int FRAME_W = $clog2(MAX_FRAME_LIMIT + 1);
   localparam int AB_W = $clog2(MAX_FRAME_LIMIT);
   localparam logic [31:0] LIMIT_CAP = 32'(MAX_FRAME_LIMIT);
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

   logic [CFG_W-1:0]   max_frame_size_ff;
   phase_type          phase_ff, phase_in;
   logic [2:0]         field_count_ff, field_count_in;
   logic [31:0]        field_shift_ff, field_shift_in;
   logic [FRAME_W-1:0] frame_remaining_ff, frame_remaining_in;
   logic [ARG_W-1:0]   args_left_ff, args_left_in;
   logic [ARG_W-1:0]   current_arg_ff, current_arg_in;
   logic [AB_W-1:0]    arg_bytes_left_ff, arg_bytes_left_in;
   logic [31:0]        limit;

   assign limit = (32'(max_frame_size_ff) < LIMIT_CAP) ? 32'(max_frame_size_ff) : LIMIT_CAP;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_size_ff  <= CFG_RESET;
         phase_ff           <= PH_HEADER;
         field_count_ff     <= '0;
         field_shift_ff     <= '0;
         frame_remaining_ff <= '0;
         args_left_ff       <= '0;
         current_arg_ff     <= '0;
         arg_bytes_left_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            max_frame_size_ff <= csr_max_frame_size;
         end
         phase_ff           <= phase_in;
         field_count_ff     <= field_count_in;
         field_shift_ff     <= field_shift_in;
         frame_remaining_ff <= frame_remaining_in;
         args_left_ff       <= args_left_in;
         current_arg_ff     <= current_arg_in;
         arg_bytes_left_ff  <= arg_bytes_left_in;
      end
   end

   always_comb begin
      logic [31:0]        shift_next;
      logic [FRAME_W-1:0] rem_dec;
      logic [AB_W-1:0]    ab_dec;
      logic [ARG_W-1:0]   args_val;
      logic               field_done;
      logic               emit_data;
      logic               verdict_go;
      logic               verdict_ok;
      logic               next_arg_go;
      logic               halt_go;
      logic [2:0]         verdict_err;
      result_type         data_res;
      result_type         verdict_res;

      phase_in           = phase_ff;
      field_count_in     = field_count_ff;
      field_shift_in     = field_shift_ff;
      frame_remaining_in = frame_remaining_ff;
      args_left_in       = args_left_ff;
      current_arg_in     = current_arg_ff;
      arg_bytes_left_in  = arg_bytes_left_ff;

      shift_next  = {field_shift_ff[23:0], data_byte};
      field_done  = (field_count_ff >= 3'd3);
      rem_dec     = (frame_remaining_ff != '0) ? frame_remaining_ff - FRAME_W'(1) : '0;
      ab_dec      = (arg_bytes_left_ff != '0) ? arg_bytes_left_ff - AB_W'(1) : '0;
      args_val    = '0;
      emit_data   = 1'b0;
      verdict_go  = 1'b0;
      verdict_ok  = 1'b0;
      next_arg_go = 1'b0;
      halt_go     = 1'b0;
      verdict_err = ERR_OVERSIZE;
      data_res    = '0;

      if (in_accept && phase_ff != PH_HALT) begin
         if (phase_ff != PH_HEADER) begin
            frame_remaining_in = rem_dec;
         end
         if (phase_ff == PH_HEADER || phase_ff == PH_TIMEOUT || phase_ff == PH_COUNT ||
             phase_ff == PH_ARGLEN) begin
            if (field_done) begin
               field_count_in = '0;
               field_shift_in = '0;
            end else begin
               field_count_in = field_count_ff + 3'd1;
               field_shift_in = shift_next;
            end
         end
         unique case (phase_ff)
            PH_HEADER: begin
               if (field_done) begin
                  if (shift_next > limit) begin
                     frame_remaining_in = '0;
                     verdict_go         = 1'b1;
                     verdict_err        = ERR_OVERSIZE;
                     halt_go            = 1'b1;
                  end else begin
                     frame_remaining_in = shift_next[FRAME_W-1:0];
                     if (shift_next < 32'd6) begin
                        verdict_go  = 1'b1;
                        verdict_err = ERR_NOT_SUBMIT;
                     end else begin
                        phase_in = PH_MAGIC;
                     end
                  end
               end
            end
            PH_MAGIC: begin
               if (field_count_ff >= MAGIC_LEN || data_byte != magic_byte(field_count_ff)) begin
                  verdict_go  = 1'b1;
                  verdict_err = ERR_NOT_SUBMIT;
               end else if (field_count_ff == MAGIC_LEN - 3'd1) begin
                  field_count_in = '0;
                  field_shift_in = '0;
                  if (rem_dec < FRAME_W'(4)) begin
                     verdict_go  = 1'b1;
                     verdict_err = ERR_SHORT_HEADER;
                  end else begin
                     phase_in = PH_TIMEOUT;
                  end
               end else begin
                  field_count_in = field_count_ff + 3'd1;
               end
            end
            PH_TIMEOUT: begin
               if (field_done) begin
                  emit_data            = 1'b1;
                  data_res.result_kind = KIND_TIMEOUT;
                  data_res.value       = shift_next;
                  if (rem_dec < FRAME_W'(4)) begin
                     verdict_go  = 1'b1;
                     verdict_err = ERR_SHORT_HEADER;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            PH_COUNT: begin
               if (field_done) begin
                  emit_data            = 1'b1;
                  data_res.result_kind = KIND_ARG_COUNT;
                  data_res.value       = shift_next;
                  if (shift_next > 32'(rem_dec >> 2)) begin
                     verdict_go  = 1'b1;
                     verdict_err = ERR_COUNT_TOO_BIG;
                  end else begin
                     args_left_in   = shift_next[ARG_W-1:0];
                     current_arg_in = '0;
                     next_arg_go    = 1'b1;
                     args_val       = shift_next[ARG_W-1:0];
                  end
               end
            end
            PH_ARGLEN: begin
               if (field_done) begin
                  emit_data            = 1'b1;
                  data_res.result_kind = KIND_ARG_LEN;
                  data_res.value       = shift_next;
                  data_res.arg_index   = current_arg_ff;
                  if (shift_next > 32'(rem_dec)) begin
                     verdict_go  = 1'b1;
                     verdict_err = ERR_ARG_TRUNCATED;
                  end else if (shift_next == 32'd0) begin
                     args_left_in   = args_left_ff - ARG_W'(1);
                     current_arg_in = current_arg_ff + ARG_W'(1);
                     next_arg_go    = 1'b1;
                     args_val       = args_left_ff - ARG_W'(1);
                  end else begin
                     arg_bytes_left_in = shift_next[AB_W-1:0];
                     phase_in          = PH_ARGBYTES;
                  end
               end
            end
            PH_ARGBYTES: begin
               emit_data            = 1'b1;
               data_res.result_kind = KIND_ARG_BYTE;
               data_res.value       = 32'(data_byte);
               data_res.arg_index   = current_arg_ff;
               arg_bytes_left_in    = ab_dec;
               if (ab_dec == '0) begin
                  args_left_in   = args_left_ff - ARG_W'(1);
                  current_arg_in = current_arg_ff + ARG_W'(1);
                  next_arg_go    = 1'b1;
                  args_val       = args_left_ff - ARG_W'(1);
               end
            end
            PH_SKIP: begin
               if (rem_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HALT: begin
            end
         endcase

         if (next_arg_go) begin
            if (args_val == '0) begin
               verdict_go  = 1'b1;
               verdict_ok  = (rem_dec == '0);
               verdict_err = ERR_TRAILING;
            end else if (rem_dec < FRAME_W'(4)) begin
               verdict_go  = 1'b1;
               verdict_err = ERR_SHORT_LENGTH;
            end else begin
               field_count_in = '0;
               field_shift_in = '0;
               phase_in       = PH_ARGLEN;
            end
         end

         if (verdict_go) begin
            field_count_in = '0;
            field_shift_in = '0;
            phase_in       = (frame_remaining_in != '0) ? PH_SKIP : PH_HEADER;
         end
         if (halt_go) begin
            phase_in = PH_HALT;
         end
      end

      verdict_res             = '0;
      verdict_res.result_kind = verdict_ok ? KIND_ACCEPTED : KIND_REJECTED;
      verdict_res.error_code  = verdict_ok ? ERR_OVERSIZE : verdict_err;
      verdict_res.frame_last  = 1'b1;

      push.count  = {1'b0, emit_data} + {1'b0, verdict_go};
      push.first  = emit_data ? data_res : verdict_res;
      push.second = verdict_res;
   end

`ifndef SYNTHESIS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("halted parser resumed without reset");

   a_header_no_remaining: assert property (@(posedge clock)
      phase_ff == PH_HEADER |-> frame_remaining_ff == '0)
      else $error("length header expected with payload bytes still owed");

   a_pair_ends_frame: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.second.frame_last && !push.first.frame_last)
      else $error("two results from one byte without a closing verdict");
`endif

endmodule

### design/sfsp_rsp_fifo.sv
module sfsp_rsp_fifo
   import sfsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         space_ok,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output result_type   head
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type       mem [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign space_ok  = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign head      = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> (count_ff + CNT_W'(push.count)) <= CNT_W'(RSP_DEPTH))
      else $error("result pushed without room");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push.count != 2'd0) |=> rsp_valid)
      else $error("pushed result not presented");
`endif

endmodule

### design/submit_frame_stream_parser.sv
// Parses a byte stream of length-prefixed SUBMIT frames and emits the timeout, argument
// count, argument lengths and argument bytes as they complete, closing each frame with an
// accept or a coded reject; a declared length above the limit halts the parser until reset.
// One request byte is taken per cycle while req_ready is high; its results are queued.
// A byte that completes a field and decides the verdict yields two results; the four-entry
// result queue drains one result per cycle while rsp_ready is high, so req_ready drops
// whenever more than two results are queued, and a byte is then held until the queue frees
// that room. Writes to csr_max_frame_size take effect at the next completed length header.
module submit_frame_stream_parser
   import sfsp_pkg::*;
#(
   parameter int MAX_FRAME_LIMIT = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_result_kind,
   output logic [31:0]      rsp_value,
   output logic [ARG_W-1:0] rsp_arg_index,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_frame_last,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_max_frame_size
);

   rsp_push_type push;
   result_type   head;
   logic         space_ok;

   assign req_ready = space_ok;

   sfsp_core #(
      .MAX_FRAME_LIMIT(MAX_FRAME_LIMIT)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .in_accept          (req_valid && req_ready),
      .data_byte          (req_data_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_max_frame_size (csr_max_frame_size),
      .push               (push)
   );

   sfsp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_result_kind = head.result_kind;
   assign rsp_value       = head.value;
   assign rsp_arg_index   = head.arg_index;
   assign rsp_error_code  = head.error_code;
   assign rsp_frame_last  = head.frame_last;

endmodule
